FILE: src/assert_macros.svh
// assertion helpers, clocked on clk with reset rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define AST_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define AST_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AST_IMPL(label, ante, cons)
`define AST_NEXT(label, ante, cons)
`endif
`endif

FILE: src/pesr_pkg.sv
// ----------------------------------------------------------------------------
// pesr_pkg
// Types and constants shared by the pulse edge serial receiver modules.
// ----------------------------------------------------------------------------
package pesr_pkg;

    localparam logic [9:0]  BIT_PERIOD_RESET   = 10'd104;
    localparam logic [15:0] BYTE_TIMEOUT_RESET = 16'd1200;
    localparam logic [7:0]  BYTE_ALL_ONES      = 8'hFF;
    localparam logic [3:0]  DIV_SAT            = 4'd9;

    localparam logic [1:0]  CFG_BIT_PERIOD     = 2'd0;
    localparam logic [1:0]  CFG_BYTE_TIMEOUT   = 2'd1;

    localparam logic        ACT_EDGE           = 1'b0;
    localparam logic        ACT_POLL           = 1'b1;

    typedef enum logic [2:0] {
        K_POLL_NOP,
        K_POLL_CLOSE,
        K_NEW_FRAME,
        K_SPIKE,
        K_BIT
    } kind_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DIVIDE,
        S_COMMIT
    } state_t;

    typedef struct packed {
        logic load_in;
        logic classify;
        logic start_div;
        logic step_div;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic check_bit;
        logic div_done;
        logic emit;
        logic out_blocked;
    } status_t;

endpackage

FILE: src/pulse_edge_serial_receiver_unit.sv
// sequence: a poll, spike or frame-start edge is classified after its transfer, then
// committed; a bit edge is classified, then divided by the repeated subtract of the
// gap divider (one subtract per cycle, at most nine), then committed; a result is
// offered the cycle after commit; one item in work at a time; a waiting
// result holds only commit and adds its stall cycles
// reset: rst_n asynchronous, active low; reset registers take their defaults at once
// ----------------------------------------------------------------------------
// pulse_edge_serial_receiver_unit
// Decodes timestamped pulse edges of a pulse-position serial bus into bytes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pulse_edge_serial_receiver_unit
#(
    parameter int FRAME_BYTES_MAX = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [31:0] time_us,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  data_byte,
    output logic [7:0]  byte_index,
    output logic        last_of_frame
);

    pesr_pkg::cmd_t    cmd;
    pesr_pkg::status_t status;

    pesr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    pesr_datapath
    #(
        .FRAME_BYTES_MAX (FRAME_BYTES_MAX)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .action        (action),
        .time_us       (time_us),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .data_byte     (data_byte),
        .byte_index    (byte_index),
        .last_of_frame (last_of_frame),
        .cmd           (cmd),
        .status        (status)
    );

    `AST_NEXT(a_one_item_in_work, in_valid && !in_stall, in_stall)
    `AST_IMPL(a_commit_not_blocked, cmd.commit, !(status.emit && status.out_blocked))
    `AST_IMPL(a_out_from_commit, $rose(out_valid), $past(cmd.commit))

endmodule

FILE: src/pesr_ctrl.sv
// ----------------------------------------------------------------------------
// pesr_ctrl
// Sequencer: accept, classify, divide the gap, commit the state update.
// ----------------------------------------------------------------------------
module pesr_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  pesr_pkg::status_t status,
    output pesr_pkg::cmd_t   cmd
);

    pesr_pkg::state_t state_reg;
    pesr_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pesr_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pesr_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = pesr_pkg::S_CHECK;
                end
            end
            pesr_pkg::S_CHECK:
            begin
                state_next = status.check_bit ? pesr_pkg::S_DIVIDE : pesr_pkg::S_COMMIT;
            end
            pesr_pkg::S_DIVIDE:
            begin
                if (status.div_done)
                begin
                    state_next = pesr_pkg::S_COMMIT;
                end
            end
            pesr_pkg::S_COMMIT:
            begin
                // hold while a result is due and the output register is still full and stalled
                if (!(status.emit && status.out_blocked))
                begin
                    state_next = pesr_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pesr_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            pesr_pkg::S_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.load_in = in_valid;
            end
            pesr_pkg::S_CHECK:
            begin
                cmd.classify  = 1'b1;
                cmd.start_div = status.check_bit;
            end
            pesr_pkg::S_DIVIDE:
            begin
                cmd.step_div = !status.div_done;
            end
            pesr_pkg::S_COMMIT:
            begin
                cmd.commit = !(status.emit && status.out_blocked);
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: src/pesr_datapath.sv
// ----------------------------------------------------------------------------
// pesr_datapath
// Config registers, receiver state, gap divider and the output register.
// ----------------------------------------------------------------------------
module pesr_datapath
#(
    parameter int FRAME_BYTES_MAX = 256
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    input  logic              action,
    input  logic [31:0]       time_us,
    input  logic              out_stall,
    output logic              out_valid,
    output logic [7:0]        data_byte,
    output logic [7:0]        byte_index,
    output logic              last_of_frame,
    input  pesr_pkg::cmd_t    cmd,
    output pesr_pkg::status_t status
);

    logic [9:0]         period_reg;
    logic [15:0]        timeout_reg;

    logic               act_reg;
    logic [31:0]        time_reg;
    pesr_pkg::kind_t    kind_reg;
    pesr_pkg::kind_t    kind_calc;
    logic [16:0]        rem_reg;
    logic [3:0]         quot_reg;

    logic [31:0]        last_edge_reg;
    logic [31:0]        deadline_reg;
    logic signed [5:0]  bitpos_reg;
    logic               open_reg;
    logic [7:0]         shift_reg;
    logic [7:0]         index_reg;
    logic               busy_reg;

    logic               out_valid_reg;
    logic [7:0]         out_byte_reg;
    logic [7:0]         out_index_reg;
    logic               out_last_reg;

    logic [9:0]         bp;
    logic [8:0]         half;
    logic [31:0]        dt;
    logic [31:0]        diff;
    logic signed [5:0]  pos;
    logic               pos_low;
    logic [8:0]         index_inc;
    logic [7:0]         index_adv;
    logic [31:0]        deadline_new;
    logic               emit;
    logic               res_last;

    assign bp   = (period_reg == 10'd0) ? 10'd1 : period_reg;
    assign half = bp[9:1];
    assign dt   = time_reg - last_edge_reg;
    assign diff = time_reg - deadline_reg;

    always_comb
    begin
        if (act_reg == pesr_pkg::ACT_POLL)
        begin
            kind_calc = (busy_reg && diff != 32'd0 && !diff[31]) ?
                        pesr_pkg::K_POLL_CLOSE : pesr_pkg::K_POLL_NOP;
        end
        else if (!busy_reg || dt > {16'd0, timeout_reg})
        begin
            kind_calc = pesr_pkg::K_NEW_FRAME;
        end
        else if (dt <= {23'd0, half})
        begin
            kind_calc = pesr_pkg::K_SPIKE;
        end
        else
        begin
            kind_calc = pesr_pkg::K_BIT;
        end
    end

    // quotient saturates at nine: any larger count already completes the byte
    assign pos          = bitpos_reg + $signed({2'b00, quot_reg});
    assign pos_low      = pos < 6'sd8;
    assign index_inc    = {1'b0, index_reg} + 9'd1;
    assign index_adv    = (index_inc >= 9'(FRAME_BYTES_MAX)) ? 8'd0 : index_inc[7:0];
    assign deadline_new = time_reg + {16'd0, timeout_reg};

    assign emit = ((kind_reg == pesr_pkg::K_POLL_CLOSE) && open_reg) ||
                  ((kind_reg == pesr_pkg::K_NEW_FRAME) && busy_reg && open_reg) ||
                  ((kind_reg == pesr_pkg::K_BIT) && !pos_low);
    assign res_last = (kind_reg != pesr_pkg::K_BIT);

    assign status.check_bit   = (kind_calc == pesr_pkg::K_BIT);
    assign status.div_done    = (rem_reg < {7'd0, bp}) || (quot_reg == pesr_pkg::DIV_SAT);
    assign status.emit        = emit;
    assign status.out_blocked = out_valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg  <= pesr_pkg::BIT_PERIOD_RESET;
            timeout_reg <= pesr_pkg::BYTE_TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pesr_pkg::CFG_BIT_PERIOD:   period_reg  <= cfg_data[9:0];
                pesr_pkg::CFG_BYTE_TIMEOUT: timeout_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // item and divider registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            act_reg  <= action;
            time_reg <= time_us;
        end
        if (cmd.classify)
        begin
            kind_reg <= kind_calc;
        end
        if (cmd.start_div)
        begin
            // gap is within the byte timeout here, so 17 bits hold the sum
            rem_reg  <= dt[16:0] + {8'd0, half};
            quot_reg <= 4'd0;
        end
        else if (cmd.step_div)
        begin
            rem_reg  <= rem_reg - {7'd0, bp};
            quot_reg <= quot_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_edge_reg <= 32'd0;
            deadline_reg  <= 32'd0;
            bitpos_reg    <= -6'sd1;
            open_reg      <= 1'b0;
            shift_reg     <= pesr_pkg::BYTE_ALL_ONES;
            index_reg     <= 8'd0;
            busy_reg      <= 1'b0;
        end
        else if (cmd.commit)
        begin
            case (kind_reg)
                pesr_pkg::K_POLL_CLOSE:
                begin
                    busy_reg   <= 1'b0;
                    open_reg   <= 1'b0;
                    bitpos_reg <= -6'sd1;
                    shift_reg  <= pesr_pkg::BYTE_ALL_ONES;
                    index_reg  <= 8'd0;
                end
                pesr_pkg::K_NEW_FRAME:
                begin
                    deadline_reg  <= deadline_new;
                    busy_reg      <= 1'b1;
                    open_reg      <= 1'b1;
                    bitpos_reg    <= -6'sd1;
                    shift_reg     <= pesr_pkg::BYTE_ALL_ONES;
                    index_reg     <= 8'd0;
                    last_edge_reg <= time_reg;
                end
                pesr_pkg::K_SPIKE:
                begin
                    last_edge_reg <= time_reg;
                end
                pesr_pkg::K_BIT:
                begin
                    last_edge_reg <= time_reg;
                    if (pos_low)
                    begin
                        if (!pos[5])
                        begin
                            shift_reg <= shift_reg & ~(8'd1 << pos[2:0]);
                        end
                        bitpos_reg <= pos;
                    end
                    else
                    begin
                        // byte complete, this edge is the next start bit
                        index_reg    <= index_adv;
                        shift_reg    <= pesr_pkg::BYTE_ALL_ONES;
                        bitpos_reg   <= -6'sd1;
                        open_reg     <= 1'b1;
                        deadline_reg <= deadline_new;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && emit)
        begin
            out_byte_reg  <= shift_reg;
            out_index_reg <= index_reg;
            out_last_reg  <= res_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign data_byte     = out_byte_reg;
    assign byte_index    = out_index_reg;
    assign last_of_frame = out_last_reg;

endmodule
